// ===== design/gnnp_pkg.sv =====
// Shared types and constants for the greedy nearest node planner.
// No dependencies; every other design file depends on this package.
package gnnp_pkg;

    localparam int NODE_CAP = 32;
    localparam int IDX_W    = $clog2(NODE_CAP);
    localparam int CNT_W    = $clog2(NODE_CAP + 1);
    localparam int COORD_W  = 24;
    localparam int ID_W     = 16;
    localparam int RAD_W    = 23;
    localparam int R2_W     = 2 * RAD_W;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int DIST_W   = SQ_W + 2;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_ROBOT = 2'd1;
    localparam logic [1:0] OP_PLAN  = 2'd2;

    localparam logic [1:0] KIND_ADD_ACK   = 2'd0;
    localparam logic [1:0] KIND_ROBOT_ACK = 2'd1;
    localparam logic [1:0] KIND_PLAN_ENT  = 2'd2;
    localparam logic [1:0] KIND_PLAN_DONE = 2'd3;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_NEAR     = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(256);
    localparam logic [0:0] ADDR_RADIUS = 1'b0;

    typedef struct packed {
        logic [ID_W-1:0]           id;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } entry_t;

    typedef struct packed {
        logic             shift;
        logic             wr_main;
        logic             wr_stage;
        logic             set_taken;
        logic             init_taken;
        logic             copy;
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] mark_idx;
        entry_t           wdata;
    } cell_ctrl_t;

endpackage

// ===== design/gnnp_if.sv =====
// Handshake interfaces for the request and result words of the planner.
// Depends on gnnp_pkg.
interface gnnp_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             opcode;
    logic [gnnp_pkg::ID_W-1:0]              node_id;
    logic signed [gnnp_pkg::COORD_W-1:0]    pos_x;
    logic signed [gnnp_pkg::COORD_W-1:0]    pos_y;
    logic signed [gnnp_pkg::COORD_W-1:0]    pos_z;

    modport source (output valid, opcode, node_id, pos_x, pos_y, pos_z, input ready);
    modport sink (input valid, opcode, node_id, pos_x, pos_y, pos_z, output ready);
endinterface

interface gnnp_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             kind;
    logic [1:0]                             add_status;
    logic [gnnp_pkg::ID_W-1:0]              out_node;
    logic signed [gnnp_pkg::COORD_W-1:0]    out_x;
    logic signed [gnnp_pkg::COORD_W-1:0]    out_y;
    logic signed [gnnp_pkg::COORD_W-1:0]    out_z;
    logic [gnnp_pkg::ID_W-1:0]              visited_node;
    logic                                   last;

    modport source (output valid, kind, add_status, out_node, out_x, out_y, out_z,
                    visited_node, last, input ready);
    modport sink (input valid, kind, add_status, out_node, out_x, out_y, out_z,
                  visited_node, last, output ready);
endinterface

// ===== design/gnnp_cell.sv =====
// One cell of the rotating node chain: a table entry, its taken flag and a staged entry.
// Depends on gnnp_pkg.
module gnnp_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [gnnp_pkg::IDX_W-1:0]    my_idx,
    input  gnnp_pkg::cell_ctrl_t          ctrl,
    input  gnnp_pkg::entry_t              prev_entry,
    input  logic                          prev_taken,
    output gnnp_pkg::entry_t              entry,
    output logic                          taken
);
    import gnnp_pkg::*;

    entry_t entry_reg;
    entry_t stage_reg;
    logic   taken_reg;
    logic   hit;
    logic   mark_hit;

    assign hit      = (ctrl.wr_idx == my_idx);
    assign mark_hit = (ctrl.mark_idx == my_idx);
    assign entry    = entry_reg;
    assign taken    = taken_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            entry_reg <= prev_entry;
        end
        else if (ctrl.copy)
        begin
            entry_reg <= stage_reg;
        end
        else if (ctrl.wr_main && hit)
        begin
            entry_reg <= ctrl.wdata;
        end
        if (ctrl.wr_stage && hit)
        begin
            stage_reg <= ctrl.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            taken_reg <= prev_taken;
        end
        else if (ctrl.init_taken)
        begin
            taken_reg <= (my_idx == '0);
        end
        else if (ctrl.set_taken && mark_hit)
        begin
            taken_reg <= 1'b1;
        end
    end

endmodule

// ===== design/gnnp_dist.sv =====
// Three-stage squared distance unit fed from the head of the node chain.
// Depends on gnnp_pkg.
module gnnp_dist (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic [gnnp_pkg::IDX_W-1:0]          in_tag,
    input  gnnp_pkg::entry_t                    in_entry,
    input  logic signed [gnnp_pkg::COORD_W-1:0] qx,
    input  logic signed [gnnp_pkg::COORD_W-1:0] qy,
    input  logic signed [gnnp_pkg::COORD_W-1:0] qz,
    output logic                                out_valid,
    output logic [gnnp_pkg::IDX_W-1:0]          out_tag,
    output gnnp_pkg::entry_t                    out_entry,
    output logic [gnnp_pkg::DIST_W-1:0]         out_dist
);
    import gnnp_pkg::*;

    logic [DIFF_W-1:0] ex, ey, ez;
    logic [DIFF_W-1:0] ax_reg, ay_reg, az_reg;
    logic [SQ_W-1:0]   sx_reg, sy_reg, sz_reg;
    logic [DIST_W-1:0] d_reg;
    logic [2:0]        v_reg;
    logic [IDX_W-1:0]  tag1_reg, tag2_reg, tag3_reg;
    entry_t            e1_reg, e2_reg, e3_reg;

    assign ex = {qx[COORD_W-1], qx} - {in_entry.x[COORD_W-1], in_entry.x};
    assign ey = {qy[COORD_W-1], qy} - {in_entry.y[COORD_W-1], in_entry.y};
    assign ez = {qz[COORD_W-1], qz} - {in_entry.z[COORD_W-1], in_entry.z};

    always_ff @(posedge clk)
    begin
        ax_reg   <= ex[DIFF_W-1] ? (~ex + 1'b1) : ex;
        ay_reg   <= ey[DIFF_W-1] ? (~ey + 1'b1) : ey;
        az_reg   <= ez[DIFF_W-1] ? (~ez + 1'b1) : ez;
        tag1_reg <= in_tag;
        e1_reg   <= in_entry;
        sx_reg   <= SQ_W'(ax_reg) * SQ_W'(ax_reg);
        sy_reg   <= SQ_W'(ay_reg) * SQ_W'(ay_reg);
        sz_reg   <= SQ_W'(az_reg) * SQ_W'(az_reg);
        tag2_reg <= tag1_reg;
        e2_reg   <= e1_reg;
        d_reg    <= DIST_W'(sx_reg) + DIST_W'(sy_reg) + DIST_W'(sz_reg);
        tag3_reg <= tag2_reg;
        e3_reg   <= e2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    assign out_valid = v_reg[2];
    assign out_tag   = tag3_reg;
    assign out_entry = e3_reg;
    assign out_dist  = d_reg;

endmodule

// ===== design/greedy_nearest_node_planner_core.sv =====
// Greedy nearest node planner: up to 32 nodes sit in a chain of cells that rotates past one
// pipelined squared distance unit. An add answers after a full rotation of the chain, the
// drain of the distance pipeline and a state that forms the word, or goes straight to that
// state when the table is full. Set-robot, and a plan over at most one node, answer in the
// next cycle. A plan over n nodes gives each word after a rotation, a drain and a forming
// state, then commits the new order in a copy state. Stalls on the result side add to all
// of these, and one request is handled at a time.
module greedy_nearest_node_planner_core (
    input  logic                        clk,
    input  logic                        rst_n,
    gnnp_req_if.sink                    req,
    gnnp_rsp_if.source                  rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [0:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import gnnp_pkg::*;

    localparam logic [2:0] S_IDLE       = 3'd0;
    localparam logic [2:0] S_ADD_SCAN   = 3'd1;
    localparam logic [2:0] S_ADD_DRAIN  = 3'd2;
    localparam logic [2:0] S_ADD_FIN    = 3'd3;
    localparam logic [2:0] S_PLAN_SCAN  = 3'd4;
    localparam logic [2:0] S_PLAN_DRAIN = 3'd5;
    localparam logic [2:0] S_PLAN_FIN   = 3'd6;
    localparam logic [2:0] S_PLAN_COPY  = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [1:0]        drain_reg, drain_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  remain_reg, remain_next;
    logic [IDX_W-1:0]  k_reg, k_next;
    logic [RAD_W-1:0]  radius_reg;
    logic [R2_W-1:0]   r2_reg;
    entry_t            robot_reg, robot_next;
    entry_t            q_reg, q_next;
    logic              full_reg, full_next;
    logic              near_reg, near_next;
    logic              best_v_reg, best_v_next;
    logic [DIST_W-1:0] best_d_reg, best_d_next;
    logic [IDX_W-1:0]  best_i_reg, best_i_next;
    entry_t            best_e_reg, best_e_next;

    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg, okind_next;
    logic [1:0]        ostat_reg, ostat_next;
    entry_t            oent_reg, oent_next;
    logic [ID_W-1:0]   ovis_reg, ovis_next;
    logic              olast_reg, olast_next;

    cell_ctrl_t        ctrl;
    entry_t            cell_entry [NODE_CAP];
    logic              cell_taken [NODE_CAP];
    logic              out_free;
    logic              req_fire;
    entry_t            req_entry;
    logic              feed_valid;
    logic              d_valid;
    logic [IDX_W-1:0]  d_tag;
    entry_t            d_entry;
    logic [DIST_W-1:0] d_dist;

    for (genvar i = 0; i < NODE_CAP; i++)
    begin : g_cell
        gnnp_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .my_idx     (IDX_W'(i)),
            .ctrl       (ctrl),
            .prev_entry (cell_entry[(i + 1) % NODE_CAP]),
            .prev_taken (cell_taken[(i + 1) % NODE_CAP]),
            .entry      (cell_entry[i]),
            .taken      (cell_taken[i])
        );
    end

    gnnp_dist u_dist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (feed_valid),
        .in_tag    (cnt_reg),
        .in_entry  (cell_entry[0]),
        .qx        (q_reg.x),
        .qy        (q_reg.y),
        .qz        (q_reg.z),
        .out_valid (d_valid),
        .out_tag   (d_tag),
        .out_entry (d_entry),
        .out_dist  (d_dist)
    );

    assign pready = 1'b1;
    assign prdata = 32'(radius_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            r2_reg     <= R2_W'(RADIUS_RESET) * R2_W'(RADIUS_RESET);
        end
        else
        begin
            if (psel && penable && pwrite && (paddr == ADDR_RADIUS))
            begin
                radius_reg <= pwdata[RAD_W-1:0];
            end
            r2_reg <= R2_W'(radius_reg) * R2_W'(radius_reg);
        end
    end

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign req_fire  = req.valid && req.ready;
    assign req_entry = '{id: req.node_id, x: req.pos_x, y: req.pos_y, z: req.pos_z};

    always_comb
    begin
        feed_valid = 1'b0;
        if (state_reg == S_ADD_SCAN)
        begin
            feed_valid = ({1'b0, cnt_reg} < count_reg);
        end
        else if (state_reg == S_PLAN_SCAN)
        begin
            feed_valid = ({1'b0, cnt_reg} < n_reg) && !cell_taken[0];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        drain_next  = drain_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        remain_next = remain_reg;
        k_next      = k_reg;
        robot_next  = robot_reg;
        q_next      = q_reg;
        full_next   = full_reg;
        near_next   = near_reg;
        best_v_next = best_v_reg;
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        best_e_next = best_e_reg;
        ov_next     = ov_reg && !rsp.ready;
        okind_next  = okind_reg;
        ostat_next  = ostat_reg;
        oent_next   = oent_reg;
        ovis_next   = ovis_reg;
        olast_next  = olast_reg;
        ctrl        = '0;
        ctrl.wr_idx = k_reg;
        ctrl.wdata  = best_e_reg;

        if (d_valid)
        begin
            if (d_dist <= DIST_W'(r2_reg))
            begin
                near_next = 1'b1;
            end
            if (!best_v_reg || (d_dist < best_d_reg))
            begin
                best_v_next = 1'b1;
                best_d_next = d_dist;
                best_i_next = d_tag;
                best_e_next = d_entry;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                cnt_next    = '0;
                drain_next  = '0;
                near_next   = 1'b0;
                best_v_next = 1'b0;
                if (req_fire)
                begin
                    case (req.opcode)
                        OP_ADD:
                        begin
                            q_next     = req_entry;
                            full_next  = (count_reg == CNT_W'(NODE_CAP));
                            state_next = (count_reg == CNT_W'(NODE_CAP)) ? S_ADD_FIN
                                                                         : S_ADD_SCAN;
                        end
                        OP_ROBOT:
                        begin
                            robot_next = req_entry;
                            ov_next    = 1'b1;
                            okind_next = KIND_ROBOT_ACK;
                            ostat_next = ST_ACCEPTED;
                            oent_next  = '{id: req.node_id, x: '0, y: '0, z: '0};
                            ovis_next  = '0;
                            olast_next = 1'b0;
                        end
                        OP_PLAN:
                        begin
                            if (count_reg <= CNT_W'(1))
                            begin
                                count_next = '0;
                                ov_next    = 1'b1;
                                okind_next = KIND_PLAN_DONE;
                                ostat_next = ST_ACCEPTED;
                                oent_next  = '0;
                                ovis_next  = robot_reg.id;
                                olast_next = 1'b1;
                            end
                            else
                            begin
                                ctrl.init_taken = 1'b1;
                                n_next      = count_reg;
                                remain_next = count_reg - CNT_W'(1);
                                k_next      = '0;
                                q_next      = robot_reg;
                                state_next  = S_PLAN_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD_SCAN, S_PLAN_SCAN:
            begin
                ctrl.shift = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == IDX_W'(NODE_CAP - 1))
                begin
                    state_next = (state_reg == S_ADD_SCAN) ? S_ADD_DRAIN : S_PLAN_DRAIN;
                end
            end
            S_ADD_DRAIN, S_PLAN_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'd2)
                begin
                    drain_next = '0;
                    state_next = (state_reg == S_ADD_DRAIN) ? S_ADD_FIN : S_PLAN_FIN;
                end
            end
            S_ADD_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = KIND_ADD_ACK;
                    oent_next  = '{id: q_reg.id, x: '0, y: '0, z: '0};
                    ovis_next  = '0;
                    olast_next = 1'b0;
                    if (full_reg)
                    begin
                        ostat_next = ST_FULL;
                    end
                    else if (near_reg)
                    begin
                        ostat_next = ST_NEAR;
                    end
                    else
                    begin
                        ostat_next   = ST_ACCEPTED;
                        ctrl.wr_main = 1'b1;
                        ctrl.wr_idx  = count_reg[IDX_W-1:0];
                        ctrl.wdata   = q_reg;
                        count_next   = count_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_PLAN_FIN:
            begin
                if (out_free)
                begin
                    ov_next        = 1'b1;
                    okind_next     = KIND_PLAN_ENT;
                    ostat_next     = ST_ACCEPTED;
                    oent_next      = best_e_reg;
                    ovis_next      = robot_reg.id;
                    olast_next     = (remain_reg == CNT_W'(1));
                    ctrl.wr_stage  = 1'b1;
                    ctrl.wr_idx    = k_reg;
                    ctrl.wdata     = best_e_reg;
                    ctrl.set_taken = 1'b1;
                    ctrl.mark_idx  = best_i_reg;
                    q_next         = best_e_reg;
                    k_next         = k_reg + 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    best_v_next    = 1'b0;
                    cnt_next       = '0;
                    state_next     = (remain_reg == CNT_W'(1)) ? S_PLAN_COPY : S_PLAN_SCAN;
                end
            end
            S_PLAN_COPY:
            begin
                ctrl.copy  = 1'b1;
                count_next = n_reg - CNT_W'(1);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            drain_reg  <= '0;
            count_reg  <= '0;
            n_reg      <= '0;
            remain_reg <= '0;
            k_reg      <= '0;
            robot_reg  <= '0;
            full_reg   <= 1'b0;
            near_reg   <= 1'b0;
            best_v_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            drain_reg  <= drain_next;
            count_reg  <= count_next;
            n_reg      <= n_next;
            remain_reg <= remain_next;
            k_reg      <= k_next;
            robot_reg  <= robot_next;
            full_reg   <= full_next;
            near_reg   <= near_next;
            best_v_reg <= best_v_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        best_d_reg   <= best_d_next;
        best_i_reg   <= best_i_next;
        best_e_reg   <= best_e_next;
        okind_reg    <= okind_next;
        ostat_reg    <= ostat_next;
        oent_reg     <= oent_next;
        ovis_reg     <= ovis_next;
        olast_reg    <= olast_next;
    end

    assign rsp.valid        = ov_reg;
    assign rsp.kind         = okind_reg;
    assign rsp.add_status   = ostat_reg;
    assign rsp.out_node     = oent_reg.id;
    assign rsp.out_x        = oent_reg.x;
    assign rsp.out_y        = oent_reg.y;
    assign rsp.out_z        = oent_reg.z;
    assign rsp.visited_node = ovis_reg;
    assign rsp.last         = olast_reg;

endmodule
